>>> hdl/uer_pkg.sv
package uer_pkg;

	localparam int CNT_W = 16;
	localparam int DIST_W = 11;
	localparam int SENSOR_COUNT_DEF = 3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam logic [CNT_W-1:0] SETTLE_RST = 16'd10;
	localparam logic [CNT_W-1:0] PULSE_RST = 16'd10;
	localparam logic [CNT_W-1:0] TIMEOUT_RST = 16'd5000;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	// Division by 58 as a multiply by a rounded-up reciprocal and a shift.
	localparam logic [31:0] DIV58_MULT = 32'd36158;
	localparam int DIV58_SHIFT = 21;

	typedef struct packed {
		logic [CNT_W-1:0] settle_ticks;
		logic [CNT_W-1:0] pulse_ticks;
		logic [CNT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_cm;
		logic [CNT_W-1:0] pulse_ticks_out;
		logic timed_out;
		logic done_res;
		logic busy_res;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

>>> hdl/uer_cfg_regs.sv
module uer_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uer_pkg::CNT_W-1:0] cfg_data,
	output uer_pkg::cfg_t cfg
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.settle_ticks <= uer_pkg::SETTLE_RST;
			cfg.pulse_ticks <= uer_pkg::PULSE_RST;
			cfg.timeout_ticks <= uer_pkg::TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				uer_pkg::REG_SETTLE: cfg.settle_ticks <= cfg_data;
				uer_pkg::REG_PULSE: cfg.pulse_ticks <= cfg_data;
				uer_pkg::REG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/uer_div58.sv
module uer_div58 (
	input  logic [uer_pkg::CNT_W-1:0] dividend,
	output logic [uer_pkg::DIST_W-1:0] quotient
);

	logic [31:0] prod;

	assign prod = 32'(dividend) * uer_pkg::DIV58_MULT;
	assign quotient = prod[uer_pkg::DIV58_SHIFT+uer_pkg::DIST_W-1:uer_pkg::DIV58_SHIFT];

endmodule

>>> hdl/uer_core.sv
module uer_core #(
	parameter int SENSOR_COUNT = uer_pkg::SENSOR_COUNT_DEF,
	parameter int SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic start_req,
	input  logic [SEL_W-1:0] sensor,
	input  logic [SENSOR_COUNT-1:0] echo_lines,
	input  uer_pkg::cfg_t cfg,
	output logic [SENSOR_COUNT-1:0] trigger_lines,
	output uer_pkg::res_t res
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SETTLE = 2'd1;
	localparam logic [1:0] PH_PULSE = 2'd2;
	localparam logic [1:0] PH_LISTEN = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [SEL_W-1:0] active_q, active_d;
	logic [uer_pkg::CNT_W-1:0] phase_cnt_q, phase_cnt_d;
	logic [uer_pkg::CNT_W-1:0] elapsed_q, elapsed_d;
	logic [uer_pkg::CNT_W-1:0] width_q, width_d;
	logic seen_rise_q, seen_rise_d;
	logic prev_echo_q, prev_echo_d;
	logic done, tmo, echo_act, echo_sel, sel_ok, arm;
	logic [uer_pkg::CNT_W-1:0] width_out;

	assign sel_ok = ({1'b0, sensor} < (SEL_W+1)'(SENSOR_COUNT));
	assign echo_sel = echo_lines[sensor];
	assign echo_act = echo_lines[active_q];

	always_comb begin
		phase_d = phase_q;
		active_d = active_q;
		phase_cnt_d = phase_cnt_q;
		elapsed_d = elapsed_q;
		width_d = width_q;
		seen_rise_d = seen_rise_q;
		prev_echo_d = prev_echo_q;
		done = 1'b0;
		tmo = 1'b0;
		width_out = '0;
		arm = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req && sel_ok) begin
					active_d = sensor;
					phase_d = PH_SETTLE;
					phase_cnt_d = '0;
					arm = (cfg.settle_ticks == '0);
				end
			end
			PH_SETTLE: begin
				phase_cnt_d = uer_pkg::sat_inc(phase_cnt_q);
				arm = (phase_cnt_d >= cfg.settle_ticks);
			end
			default: begin
				if (echo_act && !prev_echo_q) begin
					seen_rise_d = 1'b1;
					width_d = '0;
				end else if (seen_rise_q) begin
					width_d = uer_pkg::sat_inc(width_q);
					if (!echo_act && prev_echo_q) begin
						done = 1'b1;
						width_out = width_d;
					end
				end
				prev_echo_d = echo_act;
				elapsed_d = uer_pkg::sat_inc(elapsed_q);
				if (!done && (elapsed_d > cfg.timeout_ticks)) begin
					done = 1'b1;
					tmo = 1'b1;
					width_out = '0;
				end
				if (done) begin
					phase_d = PH_IDLE;
					phase_cnt_d = '0;
				end else if (phase_q == PH_PULSE) begin
					phase_cnt_d = uer_pkg::sat_inc(phase_cnt_q);
					if (phase_cnt_d >= cfg.pulse_ticks) begin
						phase_d = PH_LISTEN;
						phase_cnt_d = '0;
					end
				end
			end
		endcase
		if (arm) begin
			elapsed_d = '0;
			width_d = '0;
			seen_rise_d = 1'b0;
			prev_echo_d = (phase_q == PH_IDLE) ? echo_sel : echo_act;
			phase_d = PH_PULSE;
			phase_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			active_q <= '0;
			phase_cnt_q <= '0;
			elapsed_q <= '0;
			width_q <= '0;
			seen_rise_q <= 1'b0;
			prev_echo_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			active_q <= active_d;
			phase_cnt_q <= phase_cnt_d;
			elapsed_q <= elapsed_d;
			width_q <= width_d;
			seen_rise_q <= seen_rise_d;
			prev_echo_q <= prev_echo_d;
		end
	end

	assign trigger_lines = (phase_d == PH_PULSE) ? (SENSOR_COUNT'(1) << active_d) : '0;
	assign res.busy_res = (phase_d != PH_IDLE);
	assign res.done_res = done;
	assign res.timed_out = tmo;
	assign res.pulse_ticks_out = width_out;

	uer_div58 u_div (
		.dividend(width_out),
		.quotient(res.distance_cm)
	);

endmodule

>>> hdl/ultrasonic_echo_ranger.sv
// Ranging controller for up to SENSOR_COUNT trigger/echo ultrasonic sensors.
// Each input word on the s_ side is one microsecond tick: a start request, a
// sensor number and the sampled echo lines. Each tick yields exactly one
// output word on the m_ side with the trigger drive levels, busy, done,
// timeout, the echo width in ticks and the distance in centimeters.
// Settle, pulse and timeout lengths are set through the write port
// (index 0 settle, 1 pulse, 2 timeout); the user is to write them only while
// no tick is in flight, as the block does not enforce it. A tick is captured
// in the input register at the input handshake and passes through the
// measurement logic into the output register once the output is free. One
// word is accepted every cycle while the output is taken.
// When the receiver holds m_tready low, the output word holds, the next tick
// waits in the input register, and s_tready drops once both are full.
// Reset clears both registers and the measurement state to idle and loads
// the register defaults of 10, 10 and 5000 ticks.
module ultrasonic_echo_ranger #(
	parameter int SENSOR_COUNT = uer_pkg::SENSOR_COUNT_DEF,
	parameter int SEL_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1,
	parameter int IN_W = ((SEL_W + SENSOR_COUNT + 1 + 7) / 8) * 8,
	parameter int OUT_W = ((SENSOR_COUNT + 30 + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// start_req, sensor, echo_lines
	input  logic [IN_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// trigger_lines, busy_res, done_res, timed_out, pulse_ticks_out, distance_cm
	output logic [OUT_W-1:0] m_tdata,
	input  logic cfg_wr_en,
	input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uer_pkg::CNT_W-1:0] cfg_data
);

	localparam int RES_W = SENSOR_COUNT + 30;

	uer_pkg::cfg_t cfg;
	uer_pkg::res_t res;
	logic [SENSOR_COUNT-1:0] trigger_lines;
	logic valid_s1, adv;
	logic start_s1;
	logic [SEL_W-1:0] sensor_s1;
	logic [SENSOR_COUNT-1:0] echo_s1;
	logic [OUT_W-1:0] tdata_q;

	assign adv = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			sensor_s1 <= s_tdata[SEL_W:1];
			echo_s1 <= s_tdata[SEL_W+SENSOR_COUNT:SEL_W+1];
		end
		if (adv) begin
			tdata_q <= OUT_W'({res, trigger_lines});
		end
	end

	assign m_tdata = tdata_q;

	uer_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	uer_core #(
		.SENSOR_COUNT(SENSOR_COUNT),
		.SEL_W(SEL_W)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.start_req(start_s1),
		.sensor(sensor_s1),
		.echo_lines(echo_s1),
		.cfg(cfg),
		.trigger_lines(trigger_lines),
		.res(res)
	);

	if (RES_W > OUT_W) begin : g_bad_width
		$error("output word too narrow");
	end

endmodule

>>> hdl/uer_checker.sv
module uer_checker #(
	parameter int SENSOR_COUNT = uer_pkg::SENSOR_COUNT_DEF,
	parameter int OUT_W = ((SENSOR_COUNT + 30 + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [OUT_W-1:0] m_tdata
);

	localparam int BUSY_B = SENSOR_COUNT;
	localparam int DONE_B = SENSOR_COUNT + 1;
	localparam int TMO_B = SENSOR_COUNT + 2;
	localparam int WID_LO = SENSOR_COUNT + 3;
	localparam int DIST_LO = WID_LO + uer_pkg::CNT_W;

	logic busy, done, tmo;
	logic [uer_pkg::CNT_W-1:0] width;
	logic [uer_pkg::DIST_W-1:0] dist_cm;

	assign busy = m_tdata[BUSY_B];
	assign done = m_tdata[DONE_B];
	assign tmo = m_tdata[TMO_B];
	assign width = m_tdata[WID_LO+uer_pkg::CNT_W-1:WID_LO];
	assign dist_cm = m_tdata[DIST_LO+uer_pkg::DIST_W-1:DIST_LO];

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && done |-> !busy)
		else $error("busy still set on a finishing word");

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && tmo |-> done && (width == '0) && (dist_cm == '0))
		else $error("timeout word with a width or without done");

	a_width_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (!done || width == '0) |-> (width == '0) && (dist_cm == '0))
		else $error("width or distance reported without a finished echo");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

endmodule

bind ultrasonic_echo_ranger uer_checker #(
	.SENSOR_COUNT(SENSOR_COUNT),
	.OUT_W(OUT_W)
) u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int IN_W = 8;
	localparam int OUT_W = 40;
	localparam int SENSORS = uer_pkg::SENSOR_COUNT_DEF;
	localparam int CM_DIVISOR = 58;
	localparam int PHASE_ITEMS = 88;
	localparam int DIR_N = 24;
	localparam int LIMIT = 50000;
	localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [33:0] UNCHECKED = '0;

	typedef logic [uer_pkg::CNT_W-1:0] cnt_t;
	typedef logic [uer_pkg::DIST_W-1:0] dist_t;

	typedef enum logic [1:0] {RNG_IDLE, RNG_SETTLE, RNG_FIRE, RNG_LISTEN} rng_phase_e;

	typedef struct packed {
		logic [1:0] pad;
		logic [2:0] echo;
		logic [1:0] sensor;
		logic start;
	} tick_t;

	typedef struct packed {
		logic [6:0] pad;
		dist_t distance;
		cnt_t width;
		logic tmo;
		logic done;
		logic busy;
		logic [2:0] trig;
	} ranger_word_t;

	typedef struct packed {
		logic start;
		logic [1:0] sensor;
		logic [2:0] echo;
		logic fixed;
		logic [2:0] trig;
		logic busy;
		logic done;
		logic tmo;
		cnt_t width;
		dist_t distance;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [uer_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	cnt_t cfg_data = '0;

	cnt_t set_settle = uer_pkg::SETTLE_RST;
	cnt_t set_pulse = uer_pkg::PULSE_RST;
	cnt_t set_timeout = uer_pkg::TIMEOUT_RST;

	rng_phase_e range_phase = RNG_IDLE;
	logic [1:0] range_sensor = '0;
	cnt_t phase_cnt = '0;
	cnt_t elapsed_cnt = '0;
	cnt_t width_cnt = '0;
	logic rise_seen = 1'b0;
	logic echo_prev = 1'b0;

	ranger_word_t word_due[$];
	tick_t tick_plan[$];
	ranger_word_t got_word, want_word;
	int mismatches = 0;
	int words_seen = 0;
	int cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_left = 0;
	bit rx_held = 1'b0;

	dir_row_t dir_rows [DIR_N] = '{
		{1'b0, 2'd0, 3'b000, 1'b1, 3'b000, 1'b0, 1'b0, 1'b0, 16'd0, 11'd0},
		{1'b1, 2'd3, 3'b111, 1'b1, 3'b000, 1'b0, 1'b0, 1'b0, 16'd0, 11'd0},
		{1'b1, 2'd1, 3'b000, 1'b1, 3'b010, 1'b1, 1'b0, 1'b0, 16'd0, 11'd0},
		{1'b0, 2'd0, 3'b010, UNCHECKED},
		{1'b1, 2'd2, 3'b010, UNCHECKED},
		{1'b0, 2'd0, 3'b101, 1'b1, 3'b000, 1'b0, 1'b1, 1'b0, 16'd2, 11'd0},
		{1'b1, 2'd2, 3'b100, 1'b1, 3'b100, 1'b1, 1'b0, 1'b0, 16'd0, 11'd0},
		{1'b0, 2'd0, 3'b000, UNCHECKED},
		{1'b0, 2'd0, 3'b100, UNCHECKED},
		{1'b0, 2'd0, 3'b111, UNCHECKED},
		{1'b0, 2'd0, 3'b111, UNCHECKED},
		{1'b0, 2'd0, 3'b011, UNCHECKED},
		{1'b1, 2'd0, 3'b000, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b1, 2'd3, 3'b110, UNCHECKED},
		{1'b0, 2'd0, 3'b110, 1'b1, 3'b000, 1'b0, 1'b1, 1'b1, 16'd0, 11'd0},
		{1'b1, 2'd2, 3'b000, UNCHECKED},
		{1'b0, 2'd0, 3'b100, UNCHECKED},
		{1'b0, 2'd0, 3'b000, UNCHECKED},
		{1'b1, 2'd0, 3'b111, UNCHECKED}
	};

	ultrasonic_echo_ranger DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cnt_t bump(input cnt_t v);
		return (v == uer_pkg::CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic void arm_if_settled(input logic [2:0] echo);
		if (phase_cnt >= set_settle) begin
			elapsed_cnt = '0;
			width_cnt = '0;
			rise_seen = 1'b0;
			echo_prev = echo[range_sensor];
			range_phase = RNG_FIRE;
			phase_cnt = '0;
		end
	endfunction

	function automatic ranger_word_t range_tick(input tick_t t);
		ranger_word_t w;
		logic e;
		logic fin;
		logic tmo;
		cnt_t wout;
		w = '0;
		fin = 1'b0;
		tmo = 1'b0;
		wout = '0;
		case (range_phase)
		RNG_IDLE: begin
			if (t.start && t.sensor < SENSORS) begin
				range_sensor = t.sensor;
				range_phase = RNG_SETTLE;
				phase_cnt = '0;
				arm_if_settled(t.echo);
			end
		end
		RNG_SETTLE: begin
			phase_cnt = bump(phase_cnt);
			arm_if_settled(t.echo);
		end
		default: begin
			e = t.echo[range_sensor];
			if (e && !echo_prev) begin
				rise_seen = 1'b1;
				width_cnt = '0;
			end else if (rise_seen) begin
				width_cnt = bump(width_cnt);
				if (!e && echo_prev) begin
					fin = 1'b1;
					wout = width_cnt;
				end
			end
			echo_prev = e;
			elapsed_cnt = bump(elapsed_cnt);
			if (!fin && elapsed_cnt > set_timeout) begin
				fin = 1'b1;
				tmo = 1'b1;
				wout = '0;
			end
			if (fin) begin
				range_phase = RNG_IDLE;
				phase_cnt = '0;
			end else if (range_phase == RNG_FIRE) begin
				phase_cnt = bump(phase_cnt);
				if (phase_cnt >= set_pulse) begin
					range_phase = RNG_LISTEN;
					phase_cnt = '0;
				end
			end
		end
		endcase
		w.trig = (range_phase == RNG_FIRE) ? (3'b001 << range_sensor) : 3'b000;
		w.busy = (range_phase != RNG_IDLE);
		w.done = fin;
		w.tmo = tmo;
		w.width = wout;
		w.distance = dist_t'(wout / CM_DIVISOR);
		return w;
	endfunction

	function automatic tick_t noise_tick(input int unsigned sel, input logic lvl);
		tick_t t;
		t = IN_W'($urandom);
		t.pad = '0;
		t.start = ($urandom_range(99) < 10);
		if (sel < SENSORS)
			t.echo[sel] = lvl;
		return t;
	endfunction

	// A shot (start, echo low, echo high for the pulse width, low again) or noise ticks only.
	function automatic void plan_shot();
		tick_t t;
		int unsigned sel, pre, hi, tail, k;
		if ($urandom_range(99) < 20) begin
			k = $urandom_range(1, 8);
			repeat (k) tick_plan.push_back(noise_tick(SENSORS, 1'b0));
			return;
		end
		sel = ($urandom_range(99) < 5) ? SENSORS : $urandom_range(0, SENSORS - 1);
		pre = $urandom_range(0, 20);
		hi = ($urandom_range(99) < 15) ? $urandom_range(60, 120) : $urandom_range(1, 60);
		tail = $urandom_range(1, 3);
		if ($urandom_range(99) < 10) begin
			hi = 0;
			tail = $urandom_range(20, 60);
		end
		t = noise_tick(sel, 1'($urandom_range(0, 1)));
		t.start = 1'b1;
		t.sensor = 2'(sel);
		tick_plan.push_back(t);
		for (k = 1; k <= pre + hi + tail; k++)
			tick_plan.push_back(noise_tick(sel, (k > pre) && (k <= pre + hi)));
	endfunction

	task automatic offer_tick(input tick_t t, input logic fixed, input ranger_word_t fixed_word);
		ranger_word_t w;
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= t;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		w = range_tick(t);
		word_due.push_back(fixed ? fixed_word : w);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (word_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx, input cnt_t val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		uer_pkg::REG_SETTLE: set_settle = val;
		uer_pkg::REG_PULSE: set_pulse = val;
		uer_pkg::REG_TIMEOUT: set_timeout = val;
		default: ;
		endcase
	endtask

	task automatic load_cfg(input cnt_t settle, input cnt_t pulse, input cnt_t timeout);
		write_reg(REG_UNUSED, cnt_t'($urandom));
		write_reg(uer_pkg::REG_SETTLE, settle);
		write_reg(uer_pkg::REG_PULSE, pulse);
		write_reg(uer_pkg::REG_TIMEOUT, timeout);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic play_plan(input bit pause_mid);
		int n, i;
		n = tick_plan.size();
		for (i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				drain_results();
			offer_tick(tick_plan.pop_front(), 1'b0, '0);
		end
	endtask

	task automatic run_phase(input cnt_t settle, input cnt_t pulse, input cnt_t timeout,
			input bit pause_mid);
		drain_results();
		load_cfg(settle, pulse, timeout);
		while (tick_plan.size() < PHASE_ITEMS)
			plan_shot();
		while (tick_plan.size() > PHASE_ITEMS)
			void'(tick_plan.pop_back());
		play_plan(pause_mid);
	endtask

	task automatic run_random_phase();
		run_phase(cnt_t'($urandom_range(0, 12)), cnt_t'($urandom_range(0, 12)),
			cnt_t'(($urandom_range(99) < 30) ? $urandom_range(1, 40) :
				$urandom_range(100, 800)), 1'b0);
	endtask

	always @(negedge clk) begin
		if (!rx_held && words_seen >= 150) begin
			rx_held = 1'b1;
			rx_hold_left = 80;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = m_tdata;
			words_seen++;
			if (word_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", m_tdata);
			end else begin
				want_word = word_due.pop_front();
				if (got_word !== want_word) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: exp trig=%b busy=%b done=%b tmo=%b w=%0d cm=%0d pad=%h",
							words_seen, want_word.trig, want_word.busy, want_word.done,
							want_word.tmo, want_word.width, want_word.distance, want_word.pad);
					if (mismatches <= 10)
						$display("word %0d: got trig=%b busy=%b done=%b tmo=%b w=%0d cm=%0d pad=%h",
							words_seen, got_word.trig, got_word.busy, got_word.done,
							got_word.tmo, got_word.width, got_word.distance, got_word.pad);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		tick_t t;
		ranger_word_t want;
		int i;
		tx_idle_pct = 29;
		rx_idle_pct = 58;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_cfg(16'd0, 16'd0, 16'd6);
		for (i = 0; i < DIR_N; i++) begin
			t.pad = '0;
			t.start = dir_rows[i].start;
			t.sensor = dir_rows[i].sensor;
			t.echo = dir_rows[i].echo;
			want = {7'd0, dir_rows[i].distance, dir_rows[i].width, dir_rows[i].tmo,
				dir_rows[i].done, dir_rows[i].busy, dir_rows[i].trig};
			offer_tick(t, dir_rows[i].fixed, want);
		end

		run_phase(uer_pkg::SETTLE_RST, uer_pkg::PULSE_RST, uer_pkg::TIMEOUT_RST, 1'b1);
		run_random_phase();

		tx_idle_pct = 58;
		rx_idle_pct = 29;
		run_phase(16'd0, 16'd1, 16'd1, 1'b0);
		run_random_phase();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (2) run_random_phase();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && word_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> ultrasonic_echo_ranger.f
hdl/uer_pkg.sv
hdl/uer_cfg_regs.sv
hdl/uer_div58.sv
hdl/uer_core.sv
hdl/ultrasonic_echo_ranger.sv
hdl/uer_checker.sv
tb/testbench.sv
